FILE: design/ntpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntpm_pkg: shared types and constants of the nearest timestamp pair matcher
// Payload structs, history sizing, register map and control state codes.
// ----------------------------------------------------------------------------
package ntpm_pkg;

    localparam int HIST_DEPTH = 128;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

    localparam int TIME_W  = 63;
    localparam int SEQ_W   = 32;
    localparam int SKEW_W  = 64;
    localparam int CNT_W   = 32;
    localparam int WIN_W   = 30;

    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;
    localparam logic [CFG_AW-1:0] REG_MAX_SKEW_ADDR = CFG_AW'(0);
    localparam logic [WIN_W-1:0]  MAX_SKEW_RESET    = WIN_W'(7000000);

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] frame_time;
        logic [SEQ_W-1:0]  frame_seq;
    } frame_req_t;

    typedef struct packed {
        logic              found;
        logic              accepted;
        logic [SEQ_W-1:0]  match_seq;
        logic [TIME_W-1:0] match_time;
        logic [SKEW_W-1:0] skew;
        logic [CNT_W-1:0]  accepted_total;
        logic [CNT_W-1:0]  rejected_total;
    } match_rsp_t;

    // top -> history unit
    typedef struct packed {
        logic              push;
        logic              start;
        logic [TIME_W-1:0] frame_time;
        logic [SEQ_W-1:0]  frame_seq;
    } hist_ctrl_t;

    // history unit -> top
    typedef struct packed {
        logic              busy;
        logic              found;
        logic [TIME_W-1:0] near_dist;
        logic [TIME_W-1:0] best_time;
        logic [SEQ_W-1:0]  best_seq;
    } hist_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SKEW,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

FILE: design/nearest_timestamp_pair_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_timestamp_pair_matcher_top: pairs two camera streams by timestamp
// Stores reference frames in a history ring and answers each query frame
// with the nearest stored frame, its skew and a window decision.
// ----------------------------------------------------------------------------
// A store transfer (kind 0) is written into the history ring in the cycle it
// is taken and the block is ready again on the next cycle; it gives no
// result. A query transfer (kind 1) walks all stored entries, oldest first,
// one memory read per cycle through a single abs-difference and compare
// pipeline. No new transfer is taken while a query is being worked on. The
// result sits in an output register; a store transfer can be taken while it
// waits, and a finished query waits for that register to drain. max_skew_ns
// is an inclusive window written over the APB port at byte address 0; write
// it only while the block is idle, which the block itself does not enforce.
// Counters saturate at all ones.
// ----------------------------------------------------------------------------
module nearest_timestamp_pair_matcher_top
    import ntpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // query/store transfers
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire frame_req_t        req,
    // match results
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output match_rsp_t             rsp,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready
);

    state_t state_reg, state_next;

    hist_ctrl_t hctrl;
    hist_stat_t hstat;

    logic              req_take;
    logic              load_out;
    logic              out_free;

    logic [WIN_W-1:0]  max_skew_reg;
    logic [SKEW_W-1:0] skew_reg;
    logic [CNT_W-1:0]  acc_cnt_reg, rej_cnt_reg;
    logic [CNT_W-1:0]  acc_cnt_next, rej_cnt_next;
    logic              in_window;
    logic              rsp_valid_reg;
    match_rsp_t        rsp_reg;

    // query time held locally for the skew subtract
    logic [TIME_W-1:0] query_time_reg;

    ntpm_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hctrl),
        .stat  (hstat)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_MAX_SKEW_ADDR)
            prdata = CFG_DW'(max_skew_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_skew_reg <= MAX_SKEW_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_MAX_SKEW_ADDR)
            max_skew_reg <= pwdata[WIN_W-1:0];
    end

    // ---------------- control sequencer ----------------
    assign req_take = req_valid & req_ready;
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req.kind == KIND_QUERY)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (!hstat.busy)
                    state_next = ST_SKEW;
            end
            ST_SKEW:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready        = 1'b0;
        load_out         = 1'b0;
        hctrl.push       = 1'b0;
        hctrl.start      = 1'b0;
        hctrl.frame_time = req.frame_time;
        hctrl.frame_seq  = req.frame_seq;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                hctrl.push  = req_valid && req.kind == KIND_STORE;
                hctrl.start = req_valid && req.kind == KIND_QUERY;
            end
            ST_FINISH:
                load_out = out_free;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (hctrl.start)
            query_time_reg <= req.frame_time;
    end

    // ---------------- skew, window and counters ----------------
    // skew is stored minus query time; zero when nothing was found
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SKEW)
        begin
            if (hstat.found)
                skew_reg <= {1'b0, hstat.best_time} - {1'b0, query_time_reg};
            else
                skew_reg <= '0;
        end
    end

    assign in_window = hstat.near_dist <= TIME_W'(max_skew_reg);

    always_comb
    begin
        acc_cnt_next = acc_cnt_reg;
        rej_cnt_next = rej_cnt_reg;
        if (hstat.found)
        begin
            if (in_window)
            begin
                if (acc_cnt_reg != '1)
                    acc_cnt_next = acc_cnt_reg + CNT_W'(1);
            end
            else if (rej_cnt_reg != '1)
                rej_cnt_next = rej_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg   <= '0;
            rej_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                acc_cnt_reg   <= acc_cnt_next;
                rej_cnt_reg   <= rej_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_reg.found          <= hstat.found;
            rsp_reg.accepted       <= hstat.found & in_window;
            rsp_reg.match_seq      <= hstat.best_seq;
            rsp_reg.match_time     <= hstat.best_time;
            rsp_reg.skew           <= skew_reg;
            rsp_reg.accepted_total <= acc_cnt_next;
            rsp_reg.rejected_total <= rej_cnt_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: design/ntpm_history.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntpm_history: timestamp history ring and nearest-entry search
// Ring memory of reference frames plus a pipelined walk that reuses one
// abs-difference unit and one compare over all stored entries.
// ----------------------------------------------------------------------------
module ntpm_history
    import ntpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire hist_ctrl_t ctrl,
    output hist_stat_t      stat
);

    localparam int ENTRY_W = TIME_W + SEQ_W;

    logic [ENTRY_W-1:0] mem [HIST_DEPTH];

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [HIST_AW-1:0] oldest_reg, oldest_next;
    logic [HIST_AW-1:0] wr_slot;
    logic [HIST_AW:0]   wr_sum;

    logic               walk_reg, walk_next;
    logic [HIST_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               p1_reg, p2_reg;
    logic [TIME_W-1:0]  query_reg;

    logic [TIME_W-1:0]  rd_time;
    logic [SEQ_W-1:0]   rd_seq;
    logic [TIME_W-1:0]  diff;
    logic [TIME_W-1:0]  d_reg;
    logic [TIME_W-1:0]  cand_time_reg;
    logic [SEQ_W-1:0]   cand_seq_reg;

    logic               found_reg;
    logic [TIME_W-1:0]  near_dist_reg, best_time_reg;
    logic [SEQ_W-1:0]   best_seq_reg;

    function automatic logic [HIST_AW-1:0] ring_inc(input logic [HIST_AW-1:0] p);
        logic [HIST_AW-1:0] r;
        if (p == HIST_AW'(HIST_DEPTH - 1))
            r = '0;
        else
            r = p + HIST_AW'(1);
        return r;
    endfunction

    // next free slot while the ring is not full, else the oldest slot
    always_comb
    begin
        wr_sum = {1'b0, oldest_reg} + (HIST_AW+1)'(fill_reg);
        if (wr_sum >= (HIST_AW+1)'(HIST_DEPTH))
            wr_slot = HIST_AW'(wr_sum - (HIST_AW+1)'(HIST_DEPTH));
        else
            wr_slot = wr_sum[HIST_AW-1:0];
        if (fill_reg == FILL_W'(HIST_DEPTH))
            wr_slot = oldest_reg;
    end

    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (ctrl.push)
        begin
            if (fill_reg == FILL_W'(HIST_DEPTH))
                oldest_next = ring_inc(oldest_reg);
            else
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    // walk sequencer: one read issued per cycle
    always_comb
    begin
        walk_next   = walk_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_cnt_next = rd_cnt_reg;
        if (ctrl.start)
        begin
            walk_next   = (fill_reg != '0);
            rd_ptr_next = oldest_reg;
            rd_cnt_next = fill_reg;
        end
        else if (walk_reg)
        begin
            rd_ptr_next = ring_inc(rd_ptr_reg);
            rd_cnt_next = rd_cnt_reg - FILL_W'(1);
            if (rd_cnt_reg == FILL_W'(1))
                walk_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[wr_slot] <= {ctrl.frame_time, ctrl.frame_seq};
        if (walk_reg)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign rd_time = rd_data_reg[ENTRY_W-1:SEQ_W];
    assign rd_seq  = rd_data_reg[SEQ_W-1:0];
    assign diff    = (rd_time >= query_reg) ? (rd_time - query_reg) : (query_reg - rd_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
            walk_reg   <= 1'b0;
            rd_cnt_reg <= '0;
            p1_reg     <= 1'b0;
            p2_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            walk_reg   <= walk_next;
            rd_cnt_reg <= rd_cnt_next;
            p1_reg     <= walk_reg;
            p2_reg     <= p1_reg;
            if (ctrl.start)
                found_reg <= 1'b0;
            else if (p2_reg)
                found_reg <= 1'b1;
        end
    end

    // datapath: difference stage, then best-so-far compare (strict less: oldest wins ties)
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        if (ctrl.start)
            query_reg <= ctrl.frame_time;
        if (p1_reg)
        begin
            d_reg         <= diff;
            cand_time_reg <= rd_time;
            cand_seq_reg  <= rd_seq;
        end
        if (ctrl.start)
        begin
            near_dist_reg <= '0;
            best_time_reg <= '0;
            best_seq_reg  <= '0;
        end
        else if (p2_reg && (!found_reg || d_reg < near_dist_reg))
        begin
            near_dist_reg <= d_reg;
            best_time_reg <= cand_time_reg;
            best_seq_reg  <= cand_seq_reg;
        end
    end

    assign stat.busy      = walk_reg | p1_reg | p2_reg;
    assign stat.found     = found_reg;
    assign stat.near_dist = near_dist_reg;
    assign stat.best_time = best_time_reg;
    assign stat.best_seq  = best_seq_reg;

endmodule
`default_nettype wire

FILE: tb/nearest_timestamp_pair_matcher_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_timestamp_pair_matcher_top_tb: self-checking bench for the matcher
// Drives reference and query frames over valid/ready, sets the skew window
// over APB between phases, and checks every match result field by field
// against hand-written results or a cycle-free history ring model in the bench.
// ----------------------------------------------------------------------------
module nearest_timestamp_pair_matcher_top_tb
    import ntpm_pkg::*;
();

    localparam logic [TIME_W-1:0] TIME_TOP      = '1;
    localparam int                SETTLE_CYCLES = 140;  // longer than a full-ring query
    localparam int                PHASE_ITEMS   = 135;
    localparam int                PHASE_COUNT   = 7;

    // one row of the directed table; has_want marks a hand-written result
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] frame_time;
        logic [SEQ_W-1:0]  frame_seq;
        logic              has_want;
        match_rsp_t        want;
    } frame_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    frame_req_t        req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    match_rsp_t        rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [CFG_AW-1:0] paddr     = '0;
    logic [CFG_DW-1:0] pwdata    = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nearest_timestamp_pair_matcher_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the history ring, counters and window
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] ring_time [HIST_DEPTH];
    logic [SEQ_W-1:0]  ring_seq  [HIST_DEPTH];
    int                ring_fill   = 0;
    int                ring_oldest = 0;
    logic [CNT_W-1:0]  pair_count  = '0;
    logic [CNT_W-1:0]  miss_count  = '0;
    logic [WIN_W-1:0]  skew_window = MAX_SKEW_RESET;

    match_rsp_t        pending_matches [$];
    frame_row_t        directed_rows   [$];

    // bookkeeping
    int mismatches     = 0;
    int stores_sent    = 0;
    int queries_sent   = 0;
    int pairs_seen     = 0;
    int misses_seen    = 0;
    int windows_used   = 0;
    bit steady_flow    = 1'b0;  // no idling on either side while set
    int rsp_stall_left = 0;

    // Apply one frame to the shadow ring. Stores update the ring and return
    // nothing useful; queries walk oldest to newest, keep the first strict
    // minimum (so the oldest wins a tie) and update the saturating counters.
    function automatic match_rsp_t apply_frame(input frame_req_t f);
        match_rsp_t        r;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] best_d;
        int                slot;
        int                k;
        r      = '0;
        best_d = '0;
        if (f.kind == KIND_STORE)
        begin
            if (ring_fill < HIST_DEPTH)
            begin
                slot = (ring_oldest + ring_fill) % HIST_DEPTH;
                ring_fill++;
            end
            else
            begin
                // full ring: overwrite the oldest and move the head on
                slot        = ring_oldest;
                ring_oldest = (ring_oldest + 1) % HIST_DEPTH;
            end
            ring_time[slot] = f.frame_time;
            ring_seq[slot]  = f.frame_seq;
            return r;
        end
        for (k = 0; k < ring_fill; k++)
        begin
            slot = (ring_oldest + k) % HIST_DEPTH;
            d    = (ring_time[slot] >= f.frame_time) ? ring_time[slot] - f.frame_time
                                                     : f.frame_time - ring_time[slot];
            if (!r.found || d < best_d)
            begin
                r.found      = 1'b1;
                best_d       = d;
                r.match_time = ring_time[slot];
                r.match_seq  = ring_seq[slot];
            end
        end
        if (r.found)
        begin
            r.skew = {1'b0, r.match_time} - {1'b0, f.frame_time};
            if (best_d <= {{(TIME_W-WIN_W){1'b0}}, skew_window})
            begin
                r.accepted = 1'b1;
                if (pair_count != '1)
                    pair_count++;
            end
            else if (miss_count != '1)
                miss_count++;
        end
        r.accepted_total = pair_count;
        r.rejected_total = miss_count;
        return r;
    endfunction

    function automatic match_rsp_t make_rsp(input logic found, input logic accepted,
                                            input logic [SEQ_W-1:0] seq,
                                            input logic [TIME_W-1:0] mtime,
                                            input logic [SKEW_W-1:0] skew,
                                            input logic [CNT_W-1:0] acc_total,
                                            input logic [CNT_W-1:0] rej_total);
        match_rsp_t r;
        r.found          = found;
        r.accepted       = accepted;
        r.match_seq      = seq;
        r.match_time     = mtime;
        r.skew           = skew;
        r.accepted_total = acc_total;
        r.rejected_total = rej_total;
        return r;
    endfunction

    function automatic void add_row(input logic kind, input logic [TIME_W-1:0] ftime,
                                    input logic [SEQ_W-1:0] seq, input logic has_want,
                                    input match_rsp_t want);
        frame_row_t row;
        row.kind       = kind;
        row.frame_time = ftime;
        row.frame_seq  = seq;
        row.has_want   = has_want;
        row.want       = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long one; none while steady_flow is set.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one frame transfer, then the shadow is updated at the edge
    // where the transfer happened. Called from a rising edge.
    // ------------------------------------------------------------------
    task automatic send_frame(input frame_req_t f, input int gap, input logic has_want,
                              input match_rsp_t want);
        match_rsp_t predicted;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= f;
        do @(posedge clk); while (!req_ready);
        predicted = apply_frame(f);
        if (f.kind == KIND_QUERY)
        begin
            pending_matches.insert(pending_matches.size(), has_want ? want : predicted);
            queries_sent++;
        end
        else
            stores_sent++;
    endtask

    // APB write of the skew window: setup cycle, then access until pready.
    task automatic write_window(input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_SKEW_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        skew_window = value[WIN_W-1:0];
        windows_used++;
    endtask

    // Stop sending, let every outstanding match come back, then give the
    // block a full query time so it is surely idle.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls on rsp_ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rsp_stall_left != 0)
        begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ready      <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                rsp_stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every transfer against the oldest expectation
    // ------------------------------------------------------------------
    match_rsp_t oldest_want;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0d ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0d ns: unexpected match result %h", $time, rsp);
                mismatches++;
            end
            else
            begin
                oldest_want = pending_matches[0];
                pending_matches.delete(0);
                check_field("found",          oldest_want.found,          rsp.found);
                check_field("accepted",       oldest_want.accepted,       rsp.accepted);
                check_field("match_seq",      oldest_want.match_seq,      rsp.match_seq);
                check_field("match_time",     oldest_want.match_time,     rsp.match_time);
                check_field("skew",           oldest_want.skew,           rsp.skew);
                check_field("accepted_total", oldest_want.accepted_total, rsp.accepted_total);
                check_field("rejected_total", oldest_want.rejected_total, rsp.rejected_total);
                if (rsp.accepted)
                    pairs_seen++;
                else if (rsp.found)
                    misses_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        frame_req_t        f;
        frame_row_t        row;
        logic [TIME_W-1:0] cam_clock;
        logic [TIME_W-1:0] near;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [63:0]       wide;
        logic [63:0]       off;
        logic [63:0]       win64;
        logic [CFG_DW-1:0] value;
        int unsigned       roll;
        int                p;
        int                n;

        // Directed table. Hand-written results cover the empty ring, exact
        // hits at both ends of the time range, and the largest skew; the
        // rest (ties, window edges, duplicates) go through the shadow.
        add_row(KIND_QUERY, 63'd5, 32'hFFFF_FFFF, 1'b1,
                make_rsp(1'b0, 1'b0, '0, '0, '0, 32'd0, 32'd0));
        add_row(KIND_STORE, 63'd0, 32'h0, 1'b0, '0);
        add_row(KIND_QUERY, 63'd0, 32'h0, 1'b1,
                make_rsp(1'b1, 1'b1, 32'h0, 63'd0, 64'd0, 32'd1, 32'd0));
        add_row(KIND_STORE, TIME_TOP, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(KIND_QUERY, TIME_TOP, 32'h0, 1'b1,
                make_rsp(1'b1, 1'b1, 32'hFFFF_FFFF, TIME_TOP, 64'd0, 32'd2, 32'd0));
        // midway: the top entry is one ns nearer than zero
        add_row(KIND_QUERY, 63'h4000_0000_0000_0000, 32'h0, 1'b1,
                make_rsp(1'b1, 1'b0, 32'hFFFF_FFFF, TIME_TOP,
                         64'h3FFF_FFFF_FFFF_FFFF, 32'd2, 32'd1));
        // equal distance both sides: older entry must win
        add_row(KIND_STORE, 63'd1000, 32'h0000_000A, 1'b0, '0);
        add_row(KIND_STORE, 63'd3000, 32'h0000_000B, 1'b0, '0);
        add_row(KIND_QUERY, 63'd2000, 32'h1234_5678, 1'b0, '0);
        // window edges around a single frame (window is inclusive)
        add_row(KIND_STORE, 63'd50_000_000, 32'h0000_000C, 1'b0, '0);
        add_row(KIND_QUERY, 63'd57_000_000, 32'h0, 1'b0, '0);
        add_row(KIND_QUERY, 63'd57_000_001, 32'h0, 1'b0, '0);
        add_row(KIND_QUERY, 63'd43_000_000, 32'h0, 1'b0, '0);
        add_row(KIND_QUERY, 63'd42_999_999, 32'h0, 1'b0, '0);
        // duplicate timestamp, older sequence wins
        add_row(KIND_STORE, 63'd50_000_000, 32'h0000_000D, 1'b0, '0);
        add_row(KIND_QUERY, 63'd50_000_000, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(KIND_QUERY, 63'd1, 32'h0, 1'b0, '0);
        add_row(KIND_QUERY, TIME_TOP - 63'd1, 32'h5555_5555, 1'b0, '0);
        add_row(KIND_QUERY, 63'd0, 32'hAAAA_AAAA, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on the reset window
        foreach (directed_rows[i])
        begin
            row          = directed_rows[i];
            f.kind       = row.kind;
            f.frame_time = row.frame_time;
            f.frame_seq  = row.frame_seq;
            send_frame(f, pick_gap(), row.has_want, row.want);
        end
        drain_results();

        // Random phases, one window each: zero, an all-ones write (masked to
        // the widest value), one second, the reset value, a tiny one, then
        // random values. Most traffic is a realistic frame stream; the rest
        // is full-range noise.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'd1_000_000_000;
                3:       value = 32'd7_000_000;
                4:       value = 32'd1000;
                default: value = $urandom_range(30_000_000);
            endcase
            write_window(value);
            win64       = {{(64-WIN_W){1'b0}}, skew_window};
            steady_flow = (p == 3);
            // one phase starts near the top of the time range so it wraps
            wide      = {$urandom, $urandom};
            cam_clock = (p == 1) ? TIME_TOP - 63'd500_000_000 : wide[TIME_W-1:0];

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll        = $urandom_range(99);
                f.frame_seq = $urandom;
                if (roll < 55)
                begin
                    // reference frame; one in ten repeats the last timestamp
                    f.kind = KIND_STORE;
                    if ($urandom_range(9) != 0)
                        cam_clock = cam_clock
                                    + TIME_W'($urandom_range(20_000_000, 1_000_000));
                    f.frame_time = cam_clock;
                end
                else if (roll < 90)
                begin
                    // query near a stored frame or near the running clock
                    f.kind = KIND_QUERY;
                    near   = cam_clock;
                    if (ring_fill > 0 && $urandom_range(1) == 1)
                        near = ring_time[(ring_oldest + $urandom_range(ring_fill - 1))
                                         % HIST_DEPTH];
                    case ($urandom_range(4))
                        0:       off = 64'd0;
                        1:       off = win64;
                        2:       off = win64 + 64'd1;
                        3:       off = 64'($urandom_range(2 * skew_window + 2_000_000));
                        default: off = 64'd0;
                    endcase
                    if ($urandom_range(1) == 1)
                        off = -off;
                    f.frame_time = near + off[TIME_W-1:0];
                    // midpoint of two stored frames forces ties
                    if (ring_fill > 1 && $urandom_range(4) == 0)
                    begin
                        a    = ring_time[(ring_oldest + $urandom_range(ring_fill - 1))
                                         % HIST_DEPTH];
                        b    = ring_time[(ring_oldest + $urandom_range(ring_fill - 1))
                                         % HIST_DEPTH];
                        wide = ({1'b0, a} + {1'b0, b}) >> 1;
                        f.frame_time = wide[TIME_W-1:0];
                    end
                end
                else
                begin
                    f.kind       = ($urandom_range(1) == 1) ? KIND_QUERY : KIND_STORE;
                    wide         = {$urandom, $urandom};
                    f.frame_time = wide[TIME_W-1:0];
                end
                send_frame(f, pick_gap(), 1'b0, '0);
            end
            // sender holds off here until every match is back
            drain_results();
        end

        $display("Sent %0d reference frames and %0d queries under %0d window settings.",
                 stores_sent, queries_sent, windows_used + 1);
        $display("Matches in window: %0d, outside window: %0d, mismatches: %0d.",
                 pairs_seen, misses_seen, mismatches);
        if (mismatches == 0)
            $display("** nearest_timestamp_pair_matcher_top: PASSED **");
        else
            $display("** nearest_timestamp_pair_matcher_top: FAILED **");
        $finish;
    end

    // Watchdog: several times the slowest clean run.
    initial
    begin
        #12_000_000;
        $display("%0d ns: timeout, %0d matches still outstanding", $time,
                 pending_matches.size());
        $display("** nearest_timestamp_pair_matcher_top: FAILED **");
        $finish;
    end

endmodule
